[sv/assert_macros.svh]
// Assertion helpers included by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that an expression is never true outside reset
`define ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`endif

[sv/btk_pkg.sv]
package btk_pkg;

   localparam int VALUE_W      = 64;
   localparam int KIND_W       = 2;
   localparam int CFG_W        = 5;
   localparam int OCC_W        = 5;
   localparam int CAPACITY_DEF = 16;

   localparam logic [CFG_W-1:0] MAX_ENTRIES_RESET = 5'd16;

   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DUMP   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_NOP    = 2'd3;

   // What every cell of the chain does
   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_EVICT  = 2'd2,
      CELL_ROTATE = 2'd3
   } cell_op_type;

   typedef struct packed {
      cell_op_type        op;
      logic [VALUE_W-1:0] value;
   } cell_cmd_type;

endpackage

[sv/btk_cell.sv]
module btk_cell (
   input  logic                         clock,
   input  btk_pkg::cell_cmd_type        cmd,
   input  logic                         occupied,
   input  logic [btk_pkg::VALUE_W-1:0]  left_value,
   input  logic                         left_ge,
   input  logic [btk_pkg::VALUE_W-1:0]  right_value,
   input  logic                         right_ge,
   output logic [btk_pkg::VALUE_W-1:0]  value,
   output logic                         ge
);

   logic [btk_pkg::VALUE_W-1:0] value_ff;
   logic [btk_pkg::VALUE_W-1:0] value_in;

   // An empty slot, or a stored value not above the new one, lies at or past the insert point
   assign ge    = !occupied || ($signed(value_ff) <= $signed(cmd.value));
   assign value = value_ff;

   always_comb begin
      value_in = value_ff;
      unique case (cmd.op)
         btk_pkg::CELL_HOLD: begin
            value_in = value_ff;
         end
         btk_pkg::CELL_INSERT: begin
            // shift down behind the insert point, take the new value at it
            if (left_ge) begin
               value_in = left_value;
            end else if (ge) begin
               value_in = cmd.value;
            end
         end
         btk_pkg::CELL_EVICT: begin
            // head drops out: advance up to the slot just before the insert point
            if (!ge) begin
               value_in = right_ge ? cmd.value : right_value;
            end
         end
         btk_pkg::CELL_ROTATE: begin
            value_in = right_value;
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

[sv/bounded_top_k_keeper_top.sv]
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   req_kind, req_value
// rsp_      out        rsp_valid/rsp_stall   rsp_entry_value, rsp_entry_valid, rsp_last,
//                                            rsp_accepted, rsp_occupancy
// csr_      in         csr_wr_en             csr_wr_data (max_entries)
//
// Insert, clear and no-op are answered directly from the idle state; every cell compares and shifts in parallel.
// Dump of a non-empty store rotates the chain once around all CAPACITY cells, the head going
// out on each step, and emits the first occupancy values.
// Dump of an empty store answers directly from the idle state.
// A stalled result register holds the chain and blocks new items.
// Reset empties the store and sets max_entries to 16; stored values need no clearing.
`include "assert_macros.svh"

module bounded_top_k_keeper_top #(
   parameter int CAPACITY = btk_pkg::CAPACITY_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [btk_pkg::KIND_W-1:0]         req_kind,
   input  logic signed [btk_pkg::VALUE_W-1:0] req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [btk_pkg::VALUE_W-1:0] rsp_entry_value,
   output logic                               rsp_entry_valid,
   output logic                               rsp_last,
   output logic                               rsp_accepted,
   output logic [btk_pkg::OCC_W-1:0]          rsp_occupancy,
   input  logic                               csr_wr_en,
   input  logic [btk_pkg::CFG_W-1:0]          csr_wr_data
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int LW = (CW > btk_pkg::CFG_W) ? CW : btk_pkg::CFG_W;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_DUMP = 2'b10
   } state_type;

   state_type                     state_ff, state_in;
   logic [CW-1:0]                 count_ff, count_in;
   logic [CW-1:0]                 dump_idx_ff, dump_idx_in;
   logic [btk_pkg::CFG_W-1:0]     max_entries_ff, max_entries_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [btk_pkg::VALUE_W-1:0]   rsp_value_ff, rsp_value_in;
   logic                          rsp_entry_valid_ff, rsp_entry_valid_in;
   logic                          rsp_last_ff, rsp_last_in;
   logic                          rsp_accepted_ff, rsp_accepted_in;
   logic [btk_pkg::OCC_W-1:0]     rsp_occ_ff, rsp_occ_in;

   btk_pkg::cell_cmd_type         cmd;
   logic [btk_pkg::VALUE_W-1:0]   cell_value [CAPACITY];
   logic [CAPACITY-1:0]           cell_ge;
   logic [CAPACITY-1:0]           occupied;

   logic [LW-1:0]                 count_ext, max_ext, limit_ext;
   logic                          full;
   logic                          out_free;
   logic                          req_take;
   logic                          rsp_load;

   logic                          insert_open;
   logic                          insert_full;
   logic [CW-1:0]                 count_inc;

   assign count_ext = LW'(count_ff);
   assign max_ext   = LW'(max_entries_ff);
   assign limit_ext = (max_ext > LW'(CAPACITY)) ? LW'(CAPACITY) : max_ext;
   assign full      = (count_ext >= limit_ext);

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign req_take  = req_valid && !req_stall;

   assign insert_open = req_take && (req_kind == btk_pkg::KIND_INSERT) && !full;
   assign insert_full = req_take && (req_kind == btk_pkg::KIND_INSERT) && full;
   assign count_inc   = count_ff + 1'b1;

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic [btk_pkg::VALUE_W-1:0] left_value;
         logic                        left_ge;
         logic [btk_pkg::VALUE_W-1:0] right_value;
         logic                        right_ge;

         assign occupied[gi] = (count_ff > CW'(gi));

         if (gi == 0) begin : g_head
            assign left_value = cell_value[0];
            assign left_ge    = 1'b0;
         end else begin : g_body
            assign left_value = cell_value[gi-1];
            assign left_ge    = cell_ge[gi-1];
         end

         // tail wraps to the head so that a dump restores the order
         if (gi == CAPACITY - 1) begin : g_tail
            assign right_value = cell_value[0];
            assign right_ge    = 1'b1;
         end else begin : g_mid
            assign right_value = cell_value[gi+1];
            assign right_ge    = cell_ge[gi+1];
         end

         btk_cell u_cell (
            .clock       (clock),
            .cmd         (cmd),
            .occupied    (occupied[gi]),
            .left_value  (left_value),
            .left_ge     (left_ge),
            .right_value (right_value),
            .right_ge    (right_ge),
            .value       (cell_value[gi]),
            .ge          (cell_ge[gi])
         );
      end
   endgenerate

   always_comb begin
      state_in           = state_ff;
      count_in           = count_ff;
      dump_idx_in        = dump_idx_ff;
      max_entries_in     = csr_wr_en ? csr_wr_data : max_entries_ff;
      cmd.op             = btk_pkg::CELL_HOLD;
      cmd.value          = req_value;
      rsp_load           = 1'b0;
      rsp_value_in       = rsp_value_ff;
      rsp_entry_valid_in = rsp_entry_valid_ff;
      rsp_last_in        = rsp_last_ff;
      rsp_accepted_in    = rsp_accepted_ff;
      rsp_occ_in         = rsp_occ_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               rsp_load           = 1'b1;
               rsp_value_in       = '0;
               rsp_entry_valid_in = 1'b0;
               rsp_last_in        = 1'b1;
               rsp_accepted_in    = 1'b0;
               unique case (req_kind)
                  btk_pkg::KIND_INSERT: begin
                     // full store: a value at or above the head is dropped
                     cmd.op          = full ? btk_pkg::CELL_EVICT : btk_pkg::CELL_INSERT;
                     rsp_accepted_in = !(full && cell_ge[0]);
                     if (!full) begin
                        count_in = count_ff + 1'b1;
                     end
                  end
                  btk_pkg::KIND_DUMP: begin
                     if (count_ff != '0) begin
                        rsp_load    = 1'b0;
                        state_in    = ST_DUMP;
                        dump_idx_in = '0;
                     end
                  end
                  btk_pkg::KIND_CLEAR: begin
                     count_in = '0;
                  end
                  btk_pkg::KIND_NOP: begin
                     count_in = count_ff;
                  end
                  default: begin
                     count_in = count_ff;
                  end
               endcase
               rsp_occ_in = btk_pkg::OCC_W'(count_in);
            end
         end
         ST_DUMP: begin
            if (out_free) begin
               cmd.op = btk_pkg::CELL_ROTATE;
               if (dump_idx_ff < count_ff) begin
                  rsp_load           = 1'b1;
                  rsp_value_in       = cell_value[0];
                  rsp_entry_valid_in = 1'b1;
                  rsp_last_in        = (dump_idx_ff == count_ff - 1'b1);
                  rsp_accepted_in    = 1'b0;
                  rsp_occ_in         = btk_pkg::OCC_W'(count_ff);
               end
               dump_idx_in = dump_idx_ff + 1'b1;
               if (dump_idx_ff == CW'(CAPACITY - 1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         count_ff       <= '0;
         dump_idx_ff    <= '0;
         max_entries_ff <= btk_pkg::MAX_ENTRIES_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         dump_idx_ff    <= dump_idx_in;
         max_entries_ff <= max_entries_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_value_ff       <= rsp_value_in;
         rsp_entry_valid_ff <= rsp_entry_valid_in;
         rsp_last_ff        <= rsp_last_in;
         rsp_accepted_ff    <= rsp_accepted_in;
         rsp_occ_ff         <= rsp_occ_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_entry_value = rsp_value_ff;
   assign rsp_entry_valid = rsp_entry_valid_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_accepted    = rsp_accepted_ff;
   assign rsp_occupancy   = rsp_occ_ff;

   `ASSERT_CLK(a_count_bound, count_ff <= CW'(CAPACITY), "occupancy above capacity")
   `ASSERT_CLK(a_insert_grows, insert_open |=> count_ff == $past(count_inc), "no growth")
   `ASSERT_CLK(a_full_keeps, insert_full |=> $stable(count_ff), "full store changed")
   `ASSERT_NEVER(a_empty_dump, rsp_valid && rsp_entry_valid && rsp_occ_ff == '0, "empty dump")

endmodule
